[sv/packet_window_buffer_top_assert.svh]
// ----------------------------------------------------------------------------
// Packet window buffer assertion macros
// Clocked assertion macros shared by the packet window buffer modules.
// ----------------------------------------------------------------------------
`ifndef PACKET_WINDOW_BUFFER_TOP_ASSERT_SVH
`define PACKET_WINDOW_BUFFER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// The property must hold at every clock edge outside reset.
`define PWB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// The expression must never be true at a clock edge outside reset.
`define PWB_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);
`else
`define PWB_ASSERT(label, prop, msg)
`define PWB_ASSERT_NEVER(label, expr, msg)
`endif

`endif

[sv/pwb_pkg.sv]
// ----------------------------------------------------------------------------
// Packet window buffer package
// Types, codes and port layout constants shared by the buffer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pwb_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 7;
    localparam int OFFS_W    = 3;
    localparam int MODE_W    = 3;
    localparam int COUNT_W   = 4;
    localparam int SEQ_W     = 8;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - (BYTE_W + LEN_W + COUNT_W + 2 * SEQ_W);

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH  = 3'd0,
        MODE_POP   = 3'd1,
        MODE_READ  = 3'd2,
        MODE_DROP  = 3'd3,
        MODE_CLEAR = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_ABSENT    = 2'd1,
        STAT_TOO_LARGE = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_STREAM
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push;     // take one pushed byte
        logic drop;     // discard the oldest packet
        logic clear;    // empty the ring
        logic absent;   // report an absent packet
        logic len_rd;   // look up a slot length and latch the request
        logic remove;   // the looked-up packet is popped rather than read
        logic refuse;   // report a packet that does not fit the caller
        logic start;    // begin streaming the looked-up packet
        logic byte_rd;  // fetch the next packet byte into the output stage
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;     // a result is held and not taken this cycle
        logic held_zero;    // the ring is empty
        logic offs_absent;  // the requested offset lies beyond the held packets
        logic cap_short;    // the caller's capacity is below the packet length
        logic len_zero;     // the looked-up packet has no bytes
        logic last_byte;    // the next fetched byte ends the packet
    } stat_t;

endpackage

[sv/pwb_ctrl.sv]
// ----------------------------------------------------------------------------
// Packet window buffer controller
// Decodes each transaction and sequences length lookups and byte streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packet_window_buffer_top_assert.svh"

module pwb_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pwb_pkg::MODE_W-1:0]        s_tuser,
    input  pwb_pkg::stat_t                    stat,
    output pwb_pkg::cmd_t                     cmd
);

    pwb_pkg::ctrl_state_t state_reg;
    pwb_pkg::ctrl_state_t state_next;
    pwb_pkg::mode_t       mode;

    assign mode = pwb_pkg::mode_t'(s_tuser);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pwb_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            pwb_pkg::S_IDLE: begin
                // A new transaction may enter while the last result is being taken.
                s_tready = !stat.out_busy;
                if (s_tvalid && !stat.out_busy) begin
                    case (mode)
                        pwb_pkg::MODE_PUSH: begin
                            cmd.push = 1'b1;
                        end
                        pwb_pkg::MODE_POP: begin
                            if (stat.held_zero) begin
                                cmd.absent = 1'b1;
                            end else begin
                                cmd.len_rd = 1'b1;
                                cmd.remove = 1'b1;
                                state_next = pwb_pkg::S_CHECK;
                            end
                        end
                        pwb_pkg::MODE_READ: begin
                            if (stat.offs_absent) begin
                                cmd.absent = 1'b1;
                            end else begin
                                cmd.len_rd = 1'b1;
                                state_next = pwb_pkg::S_CHECK;
                            end
                        end
                        pwb_pkg::MODE_DROP: begin
                            cmd.drop = 1'b1;
                        end
                        pwb_pkg::MODE_CLEAR: begin
                            cmd.clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pwb_pkg::S_CHECK: begin
                if (stat.cap_short) begin
                    cmd.refuse = 1'b1;
                    state_next = pwb_pkg::S_IDLE;
                end else if (stat.len_zero) begin
                    state_next = pwb_pkg::S_IDLE;
                end else begin
                    cmd.start  = 1'b1;
                    state_next = pwb_pkg::S_STREAM;
                end
            end
            pwb_pkg::S_STREAM: begin
                if (!stat.out_busy) begin
                    cmd.byte_rd = 1'b1;
                    if (stat.last_byte) begin
                        state_next = pwb_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                state_next = pwb_pkg::S_IDLE;
            end
        endcase
    end

    `PWB_ASSERT(a_check_out_free, (state_reg == pwb_pkg::S_CHECK) |-> !stat.out_busy, "Output stage occupied during length check")
    `PWB_ASSERT(a_stream_ends_idle, (cmd.byte_rd && stat.last_byte) |=> (state_reg == pwb_pkg::S_IDLE), "Stream did not end after its last byte")

endmodule

[sv/pwb_datapath.sv]
// ----------------------------------------------------------------------------
// Packet window buffer datapath
// Ring pointers, push state, slot memories and the registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packet_window_buffer_top_assert.svh"

module pwb_datapath #(
    parameter int PACKET_SLOTS     = 8,
    parameter int MAX_PACKET_BYTES = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [pwb_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tlast,
    input  pwb_pkg::cmd_t                     cmd,
    output pwb_pkg::stat_t                    stat,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pwb_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast,
    output logic [1:0]                        m_tuser
);

    localparam int SLOT_W      = $clog2(PACKET_SLOTS);
    localparam int CNT_W       = $clog2(PACKET_SLOTS + 1);
    localparam int CUR_W       = $clog2(MAX_PACKET_BYTES + 1);
    localparam int BYTES_DEPTH = PACKET_SLOTS * MAX_PACKET_BYTES;
    localparam int ADDR_W      = $clog2(BYTES_DEPTH);
    localparam int SUM_W       = ((SLOT_W > pwb_pkg::OFFS_W) ? SLOT_W : pwb_pkg::OFFS_W) + 1;
    localparam int CMP_W       = (CNT_W > pwb_pkg::OFFS_W) ? CNT_W : pwb_pkg::OFFS_W;

    // Input fields.
    logic [pwb_pkg::BYTE_W-1:0] in_byte;
    logic [pwb_pkg::OFFS_W-1:0] in_offs;
    logic [pwb_pkg::LEN_W-1:0]  in_cap;

    assign in_byte = s_tdata[7:0];
    assign in_offs = s_tdata[10:8];
    assign in_cap  = s_tdata[17:11];

    // Ring and push state.
    logic [SLOT_W-1:0]  write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0]  read_slot_reg, read_slot_next;
    logic [CNT_W-1:0]   held_reg, held_next;
    logic [CUR_W-1:0]   cursor_reg, cursor_next;
    pwb_pkg::status_t   refusing_reg, refusing_next;

    // Pending request and stream state.
    logic [pwb_pkg::LEN_W-1:0] cap_reg;
    logic [SLOT_W-1:0]         slot_reg;
    logic                      remove_reg;
    logic [pwb_pkg::LEN_W-1:0] len_reg;
    logic [CUR_W-1:0]          idx_reg;
    logic [ADDR_W-1:0]         base_reg;

    // Memories and their read registers.
    logic [pwb_pkg::LEN_W-1:0]  len_mem [PACKET_SLOTS];
    logic [pwb_pkg::BYTE_W-1:0] byte_mem [BYTES_DEPTH];
    logic [pwb_pkg::LEN_W-1:0]  len_rd_reg;
    logic [pwb_pkg::BYTE_W-1:0] byte_rd_reg;

    // Output stage.
    logic                      out_valid_reg, out_valid_next;
    logic                      out_last_reg;
    logic [pwb_pkg::LEN_W-1:0] out_len_reg;
    pwb_pkg::status_t          out_stat_reg;
    logic                      out_is_byte_reg;

    logic                      full;
    pwb_pkg::status_t          refuse_in;
    pwb_pkg::status_t          refuse_push;
    logic                      cur_room;
    logic [CUR_W-1:0]          cursor_push;
    logic                      byte_wr;
    logic                      push_done_ok;
    logic [ADDR_W-1:0]         wr_addr;
    logic [ADDR_W-1:0]         rd_addr;
    logic [SUM_W-1:0]          offs_sum;
    logic [SUM_W-1:0]          offs_wrap;
    logic [SLOT_W-1:0]         len_rd_addr;
    logic                      res_load;
    logic                      res_last;
    logic [pwb_pkg::LEN_W-1:0] res_len;
    pwb_pkg::status_t          res_stat;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        slot_inc = (s == SLOT_W'(PACKET_SLOTS - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    // Status towards the controller.
    assign full             = (held_reg == CNT_W'(PACKET_SLOTS));
    assign stat.out_busy    = out_valid_reg && !m_tready;
    assign stat.held_zero   = (held_reg == '0);
    assign stat.offs_absent = (CMP_W'(in_offs) >= CMP_W'(held_reg));
    assign stat.cap_short   = (cap_reg < len_rd_reg);
    assign stat.len_zero    = (len_rd_reg == '0);
    assign stat.last_byte   = ((pwb_pkg::LEN_W'(idx_reg) + pwb_pkg::LEN_W'(1)) == len_reg);

    // The full check is made on the first byte only; a too-long packet keeps an
    // earlier refusal.
    assign refuse_in = (cursor_reg == '0 && refusing_reg == pwb_pkg::STAT_OK && full) ?
                       pwb_pkg::STAT_FULL : refusing_reg;
    assign cur_room  = (cursor_reg < CUR_W'(MAX_PACKET_BYTES));
    assign refuse_push = (refuse_in == pwb_pkg::STAT_OK && !cur_room) ?
                         pwb_pkg::STAT_TOO_LARGE : refuse_in;
    assign cursor_push  = cur_room ? cursor_reg + CUR_W'(1) : cursor_reg;
    assign byte_wr      = cmd.push && refuse_in == pwb_pkg::STAT_OK && cur_room;
    assign push_done_ok = cmd.push && s_tlast && refuse_push == pwb_pkg::STAT_OK;

    assign wr_addr = ADDR_W'(write_slot_reg) * ADDR_W'(MAX_PACKET_BYTES) + ADDR_W'(cursor_reg);
    assign rd_addr = base_reg + ADDR_W'(idx_reg);

    // The offset is only used when it lies below the held count, so one
    // subtraction wraps it.
    assign offs_sum    = SUM_W'(read_slot_reg) + SUM_W'(in_offs);
    assign offs_wrap   = (offs_sum >= SUM_W'(PACKET_SLOTS)) ?
                         offs_sum - SUM_W'(PACKET_SLOTS) : offs_sum;
    assign len_rd_addr = cmd.remove ? read_slot_reg : SLOT_W'(offs_wrap);

    always_comb begin
        write_slot_next = write_slot_reg;
        read_slot_next  = read_slot_reg;
        held_next       = held_reg;
        cursor_next     = cursor_reg;
        refusing_next   = refusing_reg;
        if (cmd.push) begin
            cursor_next   = cursor_push;
            refusing_next = refuse_push;
            if (s_tlast) begin
                cursor_next   = '0;
                refusing_next = pwb_pkg::STAT_OK;
                if (refuse_push == pwb_pkg::STAT_OK) begin
                    write_slot_next = slot_inc(write_slot_reg);
                    held_next       = held_reg + CNT_W'(1);
                end
            end
        end
        if ((cmd.drop && !stat.held_zero) || (cmd.start && remove_reg)) begin
            read_slot_next = slot_inc(read_slot_reg);
            held_next      = held_reg - CNT_W'(1);
        end
        if (cmd.clear) begin
            write_slot_next = '0;
            read_slot_next  = '0;
            held_next       = '0;
            cursor_next     = '0;
            refusing_next   = pwb_pkg::STAT_OK;
        end
    end

    // Result of the transaction or stream step in this cycle.
    always_comb begin
        res_load = 1'b1;
        res_last = 1'b1;
        res_len  = '0;
        res_stat = pwb_pkg::STAT_OK;
        if (cmd.byte_rd) begin
            res_last = stat.last_byte;
            res_len  = len_reg;
        end else if (cmd.push && s_tlast) begin
            res_stat = refuse_push;
            if (refuse_push == pwb_pkg::STAT_OK) begin
                res_len = pwb_pkg::LEN_W'(cursor_push);
            end
        end else if (cmd.drop) begin
            res_stat = stat.held_zero ? pwb_pkg::STAT_ABSENT : pwb_pkg::STAT_OK;
        end else if (cmd.absent) begin
            res_stat = pwb_pkg::STAT_ABSENT;
        end else if (cmd.refuse) begin
            res_stat = pwb_pkg::STAT_TOO_LARGE;
        end else if (!cmd.clear) begin
            res_load = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        if (res_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_slot_reg <= '0;
            read_slot_reg  <= '0;
            held_reg       <= '0;
            cursor_reg     <= '0;
            refusing_reg   <= pwb_pkg::STAT_OK;
            out_valid_reg  <= 1'b0;
        end else begin
            write_slot_reg <= write_slot_next;
            read_slot_reg  <= read_slot_next;
            held_reg       <= held_next;
            cursor_reg     <= cursor_next;
            refusing_reg   <= refusing_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.len_rd) begin
            cap_reg    <= in_cap;
            slot_reg   <= len_rd_addr;
            remove_reg <= cmd.remove;
        end
        if (cmd.start) begin
            len_reg  <= len_rd_reg;
            idx_reg  <= '0;
            base_reg <= ADDR_W'(slot_reg) * ADDR_W'(MAX_PACKET_BYTES);
        end else if (cmd.byte_rd) begin
            idx_reg <= idx_reg + CUR_W'(1);
        end
        if (res_load) begin
            out_last_reg    <= res_last;
            out_len_reg     <= res_len;
            out_stat_reg    <= res_stat;
            out_is_byte_reg <= cmd.byte_rd;
        end
    end

    // Slot length store.
    always_ff @(posedge aclk) begin
        if (push_done_ok) begin
            len_mem[write_slot_reg] <= pwb_pkg::LEN_W'(cursor_push);
        end
        if (cmd.len_rd) begin
            len_rd_reg <= len_mem[len_rd_addr];
        end
    end

    // Packet byte store; its read register doubles as the output byte.
    always_ff @(posedge aclk) begin
        if (byte_wr) begin
            byte_mem[wr_addr] <= in_byte;
        end
        if (cmd.byte_rd) begin
            byte_rd_reg <= byte_mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_stat_reg;
    assign m_tdata  = {{pwb_pkg::M_PAD_W{1'b0}},
                       pwb_pkg::SEQ_W'(write_slot_reg),
                       pwb_pkg::SEQ_W'(read_slot_reg),
                       pwb_pkg::COUNT_W'(held_reg),
                       out_len_reg,
                       (out_is_byte_reg ? byte_rd_reg : {pwb_pkg::BYTE_W{1'b0}})};

    `PWB_ASSERT(a_held_bound, held_reg <= CNT_W'(PACKET_SLOTS), "Held packet count exceeds the ring size")
    `PWB_ASSERT(a_cursor_bound, cursor_reg <= CUR_W'(MAX_PACKET_BYTES), "Fill cursor exceeds the slot size")
    `PWB_ASSERT_NEVER(a_refuse_cursor, (refusing_reg != pwb_pkg::STAT_OK) && (cursor_reg == '0), "Refusal pending with no byte taken")

endmodule

[sv/packet_window_buffer_top.sv]
// ----------------------------------------------------------------------------
// Packet window buffer
// Ring of packet slots used as a sliding-window send buffer.
// ----------------------------------------------------------------------------
// Pushed bytes are taken one per cycle while the result channel is not stalled,
// with no result until the last byte of the packet, which returns one status
// result. Drop, clear and absent pop/read requests return one result. A pop
// or read refused for lack of capacity returns its refusal from the check
// state, as the refusal is only known after the slot length lookup. A pop or
// read that succeeds passes the slot length lookup and check, then returns
// its bytes one per cycle while the result channel is not stalled, through
// the single read port of the packet byte memory; no new transaction is taken
// until its last byte has been loaded. Back-pressure on the result channel
// stalls the block. There is no clearing pass after reset.
`timescale 1ns / 1ps

module packet_window_buffer_top #(
    parameter int PACKET_SLOTS     = 8,
    parameter int MAX_PACKET_BYTES = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: in_byte[7:0], slot_offset[10:8], capacity[17:11], zero[23:18]
    input  logic [pwb_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tlast,
    // s_tuser: mode[2:0]
    input  logic [pwb_pkg::MODE_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: out_byte[7:0], out_length[14:8], packet_count[18:15],
    //          window_base[26:19], next_sequence[34:27], zero[39:35]
    output logic [pwb_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast,
    // m_tuser: status[1:0]
    output logic [1:0]                        m_tuser
);

    pwb_pkg::cmd_t  cmd;
    pwb_pkg::stat_t stat;

    pwb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    pwb_datapath #(
        .PACKET_SLOTS     (PACKET_SLOTS),
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
